@@ sv/kda_pkg.sv @@
// Shared types and constants for the key debouncer with auto-repeat.
package kda_pkg;

  localparam int unsigned NUM_KEYS    = 3;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned COUNT_W_DEF = 16;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef period_t [NUM_KEYS-1:0] period_arr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_LEFT  = 2'd0,
    REG_PERIOD_RIGHT = 2'd1,
    REG_PERIOD_MODE  = 2'd2
  } cfg_reg_e;

  localparam period_t PERIOD_LEFT_RST  = 16'd50;
  localparam period_t PERIOD_RIGHT_RST = 16'd50;
  localparam period_t PERIOD_MODE_RST  = 16'd0;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_FORCE = 1'b1
  } op_e;

  localparam logic [2:0] PAT_HELD    = 3'b111;
  localparam logic [2:0] PAT_PRESS   = 3'b011;
  localparam logic [2:0] PAT_RELEASE = 3'b100;

  typedef struct packed {
    logic ev;
    logic level_d;
    logic level_q;
  } key_stat_t;

endpackage

@@ sv/kda_cfg.sv @@
// Repeat period registers with a plain write port.
module kda_cfg
  import kda_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PERIOD_W-1:0]  cfg_data_i,
  output period_arr_t          period_o
);

  period_arr_t period_q, period_d;

  always_comb begin
    period_d = period_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD_LEFT:  period_d[0] = cfg_data_i;
        REG_PERIOD_RIGHT: period_d[1] = cfg_data_i;
        REG_PERIOD_MODE:  period_d[2] = cfg_data_i;
        default:          period_d = period_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q[0] <= PERIOD_LEFT_RST;
      period_q[1] <= PERIOD_RIGHT_RST;
      period_q[2] <= PERIOD_MODE_RST;
    end else begin
      period_q <= period_d;
    end
  end

  assign period_o = period_q;

endmodule

@@ sv/kda_key.sv @@
// Per-key sample history, debounced level and hold counter.
module kda_key
  import kda_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tick_i,
  input  logic      sample_i,
  input  period_t   period_i,
  output key_stat_t stat_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

  logic [1:0]             hist_q, hist_d;
  logic                   level_q, level_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [2:0]             pat;
  logic                   ev;

  assign pat     = {hist_q, sample_i};
  assign cnt_inc = cnt_q + COUNT_WIDTH'(1);

  always_comb begin
    hist_d  = pat[1:0];
    level_d = level_q;
    cnt_d   = cnt_q;
    ev      = 1'b0;
    case (pat)
      PAT_HELD: begin
        if (period_i != '0) begin
          if (CMP_W'(cnt_inc) == CMP_W'(period_i)) begin
            cnt_d = '0;
            ev    = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      PAT_PRESS: begin
        if (!level_q) begin
          level_d = 1'b1;
          cnt_d   = '0;
          ev      = 1'b1;
        end
      end
      PAT_RELEASE: begin
        if (level_q) begin
          level_d = 1'b0;
          ev      = 1'b1;
        end
      end
      default: ev = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      level_q <= 1'b0;
      cnt_q   <= '0;
    end else if (tick_i) begin
      hist_q  <= hist_d;
      level_q <= level_d;
      cnt_q   <= cnt_d;
    end
  end

  assign stat_o.ev      = ev;
  assign stat_o.level_d = level_d;
  assign stat_o.level_q = level_q;

endmodule

@@ sv/key_debounce_autorepeat_top.sv @@
// Top level of the three-key debouncer with auto-repeat.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------------------
//   input    | in_valid_i / in_ready_o     | operation, key_samples, force_mask, quiet
//   result   | out_valid_o / out_ready_i   | event_mask, level_mask
//   config   | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// One beat per cycle while no result is stalled; its result is registered and shows in the cycle after acceptance.
// Throughput is set by the single result register: a new beat enters while it drains.
// Reset clears history, levels, hold counters and loads the default periods.
// A stalled result holds in_ready_o low until it is taken.
module key_debounce_autorepeat_top
  import kda_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [NUM_KEYS-1:0]  key_samples_i,
  input  logic [NUM_KEYS-1:0]  force_mask_i,
  input  logic                 quiet_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [NUM_KEYS-1:0]  event_mask_o,
  output logic [NUM_KEYS-1:0]  level_mask_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PERIOD_W-1:0]  cfg_data_i
);

  period_arr_t               period;
  key_stat_t [NUM_KEYS-1:0]  stat;
  logic                      accept;
  logic                      tick;
  logic [NUM_KEYS-1:0]       ev_tick, lvl_d, lvl_q;
  logic [NUM_KEYS-1:0]       event_d, level_d;
  logic                      out_valid_q, out_valid_d;
  logic [NUM_KEYS-1:0]       event_q, level_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tick       = accept && (op_e'(operation_i) == OP_TICK);

  kda_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .period_o   (period)
  );

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kda_key #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_key (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tick_i   (tick),
      .sample_i (key_samples_i[k]),
      .period_i (period[k]),
      .stat_o   (stat[k])
    );
    assign ev_tick[k] = stat[k].ev;
    assign lvl_d[k]   = stat[k].level_d;
    assign lvl_q[k]   = stat[k].level_q;
  end

  always_comb begin
    if (op_e'(operation_i) == OP_FORCE) begin
      event_d = force_mask_i;
      level_d = lvl_q;
    end else begin
      event_d = quiet_i ? '0 : ev_tick;
      level_d = lvl_d;
    end
  end

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_d;
      level_q <= level_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_mask_o = event_q;
  assign level_mask_o = level_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat left no result");

  a_quiet_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !operation_i && quiet_i) |=> (event_mask_o == '0))
    else $error("quiet tick reported an event");

  a_force_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i) |=> (event_mask_o == $past(force_mask_i)))
    else $error("forced report does not match mask");

  a_force_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i) |=> (level_mask_o == $past(lvl_q) && lvl_q == $past(lvl_q)))
    else $error("force changed a debounced level");

endmodule
